// ===== src/insertion_sorter_macros.svh =====
// Assertion macros shared by the insertion sorter RTL.
`ifndef INSERTION_SORTER_MACROS_SVH
`define INSERTION_SORTER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ISRT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("insertion_sorter: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ISRT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("insertion_sorter: next-cycle check failed");

`endif

// ===== src/isrt_pkg.sv =====
// Package with the shared types and constants of the insertion sorter.
`default_nettype none

package isrt_pkg;

    localparam int MAX_ELEMENTS = 32;
    localparam int VALUE_W      = 32;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_SHIFT
    } t_cell_op;

    typedef enum logic {
        ST_LOAD,
        ST_DRAIN
    } t_state;

    typedef struct packed {
        t_cell_op                  op;
        logic signed [VALUE_W-1:0] value;
    } t_cell_ctl;

endpackage

`default_nettype wire

// ===== src/isrt_cell.sv =====
// One cell of the sorting chain: holds a single stored value and its valid bit.
`default_nettype none

module isrt_cell (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  isrt_pkg::t_cell_ctl                   i_ctl,
    input  wire                                   i_prev_gt,
    input  wire                                   i_prev_valid,
    input  wire signed [isrt_pkg::VALUE_W-1:0]    i_prev_val,
    input  wire                                   i_next_valid,
    input  wire signed [isrt_pkg::VALUE_W-1:0]    i_next_val,
    output logic                                  o_valid,
    output logic signed [isrt_pkg::VALUE_W-1:0]   o_val,
    output logic                                  o_gt
);

    logic                                r_valid;
    logic signed [isrt_pkg::VALUE_W-1:0] r_val;
    logic                                n_valid;
    logic signed [isrt_pkg::VALUE_W-1:0] n_val;

    // An empty cell counts as holding a value above everything.
    assign o_gt    = !r_valid || (r_val > i_ctl.value);
    assign o_valid = r_valid;
    assign o_val   = r_val;

    always_comb begin
        n_valid = r_valid;
        n_val   = r_val;
        case (i_ctl.op)
            isrt_pkg::OP_INSERT: begin
                if (o_gt) begin
                    // Move the larger neighbor up, or take the new value at the boundary.
                    n_val   = i_prev_gt ? i_prev_val : i_ctl.value;
                    n_valid = r_valid || i_prev_valid;
                end
            end
            isrt_pkg::OP_SHIFT: begin
                n_val   = i_next_val;
                n_valid = i_next_valid;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

`default_nettype wire

// ===== src/insertion_sorter.sv =====
// Top level of the streaming insertion sorter built from a chain of cells.
`default_nettype none

// Streaming ascending sorter.
// Slave channel (s_axis_*): one signed 32-bit value per request, tlast marks the
// final value of a set. Each accepted value is inserted into a chain of
// MAX_ELEMENTS cells in the cycle it is taken: every cell compares against the
// broadcast value at once, so loading runs at one request per cycle.
// After a request with tlast, the chain drains through the master channel
// (m_axis_*) smallest first, starting the next cycle, one item per cycle while
// m_axis_tready is high. tuser[0] marks the largest (final) item, tuser[1]
// reports that values were dropped because the chain was full.
// The drain shifts the chain down one cell per output, and s_axis_tready is low
// for the whole drain.
// When the receiver stalls, the chain and the output hold unchanged.
// Values arriving with the chain full are dropped and flag the set.
// Reset empties the chain, clears the overflow flag and returns to loading.
module insertion_sorter (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [31:0] s_axis_tdata,   // [31:0] value
    input  wire         s_axis_tlast,   // last
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] sorted_value
    output logic [1:0]  m_axis_tuser    // [0] final_res, [1] overflowed
);

`include "insertion_sorter_macros.svh"

    localparam int N = isrt_pkg::MAX_ELEMENTS;

    isrt_pkg::t_state    r_state;
    isrt_pkg::t_state    n_state;
    logic                r_overflow;
    logic                n_overflow;
    isrt_pkg::t_cell_ctl w_ctl;

    logic                                w_valid [N];
    logic signed [isrt_pkg::VALUE_W-1:0] w_val   [N];
    logic                                w_gt    [N];

    logic w_in_acc;
    logic w_out_acc;
    logic w_full;
    logic w_final;

    assign w_full    = w_valid[N-1];
    assign w_final   = !w_valid[1];
    assign w_in_acc  = s_axis_tvalid && s_axis_tready;
    assign w_out_acc = m_axis_tvalid && m_axis_tready;

    // Chain of cells; cell 0 holds the smallest value.
    for (genvar g = 0; g < N; g++) begin : g_cell
        logic                                w_pgt;
        logic                                w_pvalid;
        logic signed [isrt_pkg::VALUE_W-1:0] w_pval;
        logic                                w_nvalid;
        logic signed [isrt_pkg::VALUE_W-1:0] w_nval;

        if (g == 0) begin : g_first
            assign w_pgt    = 1'b0;
            assign w_pvalid = 1'b1;
            assign w_pval   = '0;
        end else begin : g_mid
            assign w_pgt    = w_gt[g-1];
            assign w_pvalid = w_valid[g-1];
            assign w_pval   = w_val[g-1];
        end

        if (g == N-1) begin : g_top
            assign w_nvalid = 1'b0;
            assign w_nval   = '0;
        end else begin : g_low
            assign w_nvalid = w_valid[g+1];
            assign w_nval   = w_val[g+1];
        end

        isrt_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_prev_gt    (w_pgt),
            .i_prev_valid (w_pvalid),
            .i_prev_val   (w_pval),
            .i_next_valid (w_nvalid),
            .i_next_val   (w_nval),
            .o_valid      (w_valid[g]),
            .o_val        (w_val[g]),
            .o_gt         (w_gt[g])
        );
    end

    // Next state: drain after a last request, load again after the final item.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            isrt_pkg::ST_LOAD: begin
                if (w_in_acc && s_axis_tlast) begin
                    n_state = isrt_pkg::ST_DRAIN;
                end
            end
            isrt_pkg::ST_DRAIN: begin
                if (w_out_acc && w_final) begin
                    n_state = isrt_pkg::ST_LOAD;
                end
            end
            default: n_state = isrt_pkg::ST_LOAD;
        endcase
    end

    // Outputs and chain command.
    always_comb begin
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        w_ctl.op      = isrt_pkg::OP_HOLD;
        w_ctl.value   = $signed(s_axis_tdata);
        n_overflow    = r_overflow;
        unique case (r_state)
            isrt_pkg::ST_LOAD: begin
                s_axis_tready = 1'b1;
                if (w_in_acc) begin
                    // Drop the value when every cell is taken.
                    if (w_full) begin
                        n_overflow = 1'b1;
                    end else begin
                        w_ctl.op = isrt_pkg::OP_INSERT;
                    end
                end
            end
            isrt_pkg::ST_DRAIN: begin
                m_axis_tvalid = 1'b1;
                if (w_out_acc) begin
                    w_ctl.op = isrt_pkg::OP_SHIFT;
                    if (w_final) begin
                        n_overflow = 1'b0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign m_axis_tdata = w_val[0];
    assign m_axis_tuser = {r_overflow, w_final};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= isrt_pkg::ST_LOAD;
            r_overflow <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_overflow <= n_overflow;
        end
    end

    // No request is taken while the chain drains.
    `ISRT_ASSERT_IMP(a_no_load_in_drain, i_clk, i_rst_n, m_axis_tvalid, !s_axis_tready)
    // The bottom cell always holds a value while results are offered.
    `ISRT_ASSERT_IMP(a_drain_has_data, i_clk, i_rst_n, m_axis_tvalid, w_valid[0])
    // A dropped value is flagged for the set.
    `ISRT_ASSERT_NXT(a_drop_flags, i_clk, i_rst_n, w_in_acc && w_full, r_overflow)
    // After the final item the chain is empty and loading resumes.
    `ISRT_ASSERT_NXT(a_final_empties, i_clk, i_rst_n, w_out_acc && w_final,
                     s_axis_tready && !w_valid[0])

endmodule

`default_nettype wire

// ===== tb/sv/tb_insertion_sorter.sv =====
// Self-checking testbench for the streaming insertion sorter.
module tb_insertion_sorter;

    import isrt_pkg::*;

    localparam int N_DIR       = 21;
    localparam int N_RANDOM    = 400;
    localparam int CYCLE_LIMIT = 500000;
    // Longest quiet stretch after the last result: a full drain plus margin.
    localparam int DRAIN_WAIT  = 2 * MAX_ELEMENTS + 8;

    // One emitted item as seen on the master side.
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               is_largest;
        logic               dropped;
    } sorted_item_t;

    // One request toward the sorter. Rows with has_typed carry a hand-typed
    // result: a lone last value on an empty store comes straight back,
    // marked largest, with no drop flag.
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               last;
        logic               has_typed;
        logic [VALUE_W-1:0] typed_value;
    } sort_req_t;

    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_COIN,
        RX_PATTERN,
        RX_SPARSE
    } rx_mode_t;

    typedef enum logic [1:0] {
        VAL_FULL,
        VAL_NARROW,
        VAL_EDGE
    } val_style_t;

    logic               i_clk;
    logic               i_rst_n = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [31:0]        s_tdata = '0;
    logic               s_tlast = 1'b0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [31:0]        m_tdata;
    logic [1:0]         m_tuser;

    sort_req_t          dir_tbl [N_DIR];
    sort_req_t          req_q [$];
    sorted_item_t       sorted_exp_q [$];
    int                 req_idx = 0;
    int                 mismatch_cnt = 0;
    int                 cycle_cnt = 0;
    bit                 sending = 1'b0;

    // Predictor state: the ascending list, its fill and the drop flag.
    logic signed [VALUE_W-1:0] list_mdl [MAX_ELEMENTS];
    int                 count_mdl = 0;
    bit                 dropped_mdl = 1'b0;

    insertion_sorter DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),      // [31:0] value
        .s_axis_tlast  (s_tlast),      // last
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),      // [31:0] sorted_value
        .m_axis_tuser  (m_tuser)       // [0] final_res, [1] overflowed
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Insert one accepted value into the predicted list; on last, queue the
    // whole list smallest first and empty the store.
    task automatic sort_insert(input logic [VALUE_W-1:0] v, input logic last);
        int pos;
        if (count_mdl >= MAX_ELEMENTS) begin
            dropped_mdl = 1'b1;
        end else begin
            pos = count_mdl;
            // Equal values stay below the newcomer to keep arrival order.
            while (pos > 0 && list_mdl[pos-1] > $signed(v)) begin
                list_mdl[pos] = list_mdl[pos-1];
                pos--;
            end
            list_mdl[pos] = v;
            count_mdl++;
        end
        if (last) begin
            for (int k = 0; k < count_mdl; k++)
                sorted_exp_q.push_back('{list_mdl[k], k == count_mdl - 1, dropped_mdl});
            count_mdl   = 0;
            dropped_mdl = 1'b0;
        end
    endtask

    function automatic logic [VALUE_W-1:0] pick_value(val_style_t style);
        logic [VALUE_W-1:0] edges [6];
        edges = '{32'h8000_0000, 32'h8000_0001, 32'hFFFF_FFFF,
                  32'h0000_0000, 32'h0000_0001, 32'h7FFF_FFFF};
        case (style)
            VAL_NARROW: return $urandom_range(0, 9) - 5;
            VAL_EDGE:   return edges[$urandom_range(0, 5)];
            default:    return $urandom;
        endcase
    endfunction

    task automatic report(input string what, input sorted_item_t want,
                          input sorted_item_t got);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
            $display("%s: expected value %0d last %0b drop %0b, got value %0d last %0b drop %0b",
                     what, $signed(want.value), want.is_largest, want.dropped,
                     $signed(got.value), got.is_largest, got.dropped);
    endtask

    // Build the request list: directed table first, then random sets.
    initial begin
        val_style_t style;
        int         set_len;
        int         n_rand;
        dir_tbl = '{
            // lone edge values on an empty store come back unchanged
            '{32'h7FFF_FFFF, 1'b1, 1'b1, 32'h7FFF_FFFF},
            '{32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000},
            '{32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000},
            '{32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF},
            // mixed set with duplicates and both extremes
            '{32'd5,         1'b0, 1'b0, 32'd0},
            '{32'h7FFF_FFFF, 1'b0, 1'b0, 32'd0},
            '{-32'sd3,       1'b0, 1'b0, 32'd0},
            '{32'h8000_0000, 1'b0, 1'b0, 32'd0},
            '{32'd5,         1'b0, 1'b0, 32'd0},
            '{32'd0,         1'b0, 1'b0, 32'd0},
            '{-32'sd3,       1'b0, 1'b0, 32'd0},
            '{32'd1,         1'b1, 1'b0, 32'd0},
            // descending: every insert shifts the whole list
            '{32'd3,         1'b0, 1'b0, 32'd0},
            '{32'd2,         1'b0, 1'b0, 32'd0},
            '{32'd1,         1'b1, 1'b0, 32'd0},
            // ascending: every insert lands on top
            '{32'd1,         1'b0, 1'b0, 32'd0},
            '{32'd2,         1'b0, 1'b0, 32'd0},
            '{32'd3,         1'b1, 1'b0, 32'd0},
            // equal pair
            '{32'd7,         1'b0, 1'b0, 32'd0},
            '{32'd7,         1'b1, 1'b0, 32'd0},
            '{32'hFFFF_FFFE, 1'b1, 1'b0, 32'd0}
        };
        for (int i = 0; i < N_DIR; i++)
            req_q.push_back(dir_tbl[i]);

        // Random sets, each closed by a last. Most are short; some fill the
        // store exactly or run past it so that values get dropped.
        n_rand = 0;
        while (n_rand < N_RANDOM) begin
            case ($urandom_range(0, 9))
                0, 1:    set_len = $urandom_range(MAX_ELEMENTS - 2, MAX_ELEMENTS + 6);
                2:       set_len = 1;
                default: set_len = $urandom_range(2, 12);
            endcase
            style = val_style_t'($urandom_range(0, 2));
            for (int k = 0; k < set_len; k++)
                req_q.push_back('{pick_value(style), k == set_len - 1, 1'b0, 32'd0});
            n_rand += set_len;
        end
    end

    // Sender: bursts of random length separated by random gaps. Hold the
    // request steady until it is taken.
    always @(posedge i_clk) begin : sender
        int   burst_left;
        int   gap_left;
        logic fire;
        logic nxt_valid;
        logic [31:0] nxt_data;
        logic nxt_last;
        int   n0;
        fire = i_rst_n && s_tvalid && s_tready;
        if (fire) begin
            n0 = sorted_exp_q.size();
            sort_insert(req_q[req_idx].value, req_q[req_idx].last);
            if (req_q[req_idx].has_typed)
                sorted_exp_q[n0] = '{req_q[req_idx].typed_value, 1'b1, 1'b0};
            req_idx++;
        end
        if (sending && !(s_tvalid && !fire)) begin
            nxt_valid = 1'b0;
            nxt_data  = s_tdata;
            nxt_last  = s_tlast;
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
            if (gap_left > 0) begin
                gap_left--;
            end else if (req_idx < req_q.size()) begin
                nxt_valid = 1'b1;
                nxt_data  = req_q[req_idx].value;
                nxt_last  = req_q[req_idx].last;
                burst_left--;
            end
            s_tvalid <= nxt_valid;
            s_tdata  <= nxt_data;
            s_tlast  <= nxt_last;
        end
    end

    // Receiver: check each taken item, then pick the next ready from a
    // stall mode that is picked anew each time the 7-bit phase counter wraps.
    always @(posedge i_clk) begin : receiver
        rx_mode_t     mode;
        logic [31:0]  pattern;
        logic [6:0]   phase;
        sorted_item_t got;
        sorted_item_t want;
        logic         rdy;
        // Restart the stall schedule while reset is held.
        if (!i_rst_n)
            phase = '0;
        if (i_rst_n && m_tvalid && m_tready) begin
            got = '{m_tdata, m_tuser[0], m_tuser[1]};
            if (sorted_exp_q.size() == 0) begin
                report("unexpected item", '0, got);
            end else begin
                want = sorted_exp_q.pop_front();
                if (got.value !== want.value || got.is_largest !== want.is_largest ||
                    got.dropped !== want.dropped)
                    report("mismatch", want, got);
            end
        end
        if (phase == 0) begin
            mode    = rx_mode_t'($urandom_range(0, 3));
            pattern = $urandom;
        end
        phase = phase + 1;
        case (mode)
            RX_COIN:    rdy = $urandom_range(0, 1);
            RX_PATTERN: rdy = pattern[phase[4:0]];
            RX_SPARSE:  rdy = ($urandom_range(0, 3) == 0);
            default:    rdy = 1'b1;
        endcase
        m_tready <= rdy;
    end

    // Watchdog.
    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        sending = 1'b1;
        while (req_idx < req_q.size())
            @(posedge i_clk);
        while (sorted_exp_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatch_cnt == 0 && sorted_exp_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
